// ===== rtl/core/besm_pkg.sv =====
// ----------------------------------------------------------------------------
// besm_pkg
// Shared types and constants of the block event state memory.
// ----------------------------------------------------------------------------
package besm_pkg;

  localparam int unsigned MAX_BLOCKS_DEF       = 256;
  localparam int unsigned MAX_BLOCK_LENGTH_DEF = 1024;

  localparam int unsigned EVENT_W     = 64;
  localparam int unsigned RANGE_LEN_W = 19;
  localparam int unsigned BLOCK_LEN_W = 11;
  localparam int unsigned BLOCK_NUM_W = 8;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned REPLY_W     = 2;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned S_TDATA_W   = 80;
  localparam int unsigned M_TDATA_W   = 72;

  // The restoring divider retires one quotient bit of the range offset per step.
  localparam int unsigned DIV_STEPS = RANGE_LEN_W;

  localparam logic [RANGE_LEN_W-1:0] RANGE_LEN_RST = 19'd1024;
  localparam logic [BLOCK_LEN_W-1:0] BLOCK_LEN_RST = 11'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_BASE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_LENGTH = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_RECORD     = 2'd0,
    KIND_IDENTIFIED = 2'd1,
    KIND_QUERY      = 2'd2,
    KIND_READ       = 2'd3
  } kind_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic setup;
    logic div_step;
    logic index;
    logic mul;
    logic update;
    logic finish;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_read;
  } status_t;

  typedef struct packed {
    logic [REPLY_W-1:0] reply_code;
    logic [EVENT_W-1:0] current_event;
    logic               block_known;
    logic               in_range;
  } result_t;

endpackage

// ===== rtl/core/besm_ram.sv =====
// ----------------------------------------------------------------------------
// besm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module besm_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/besm_ctrl.sv =====
// ----------------------------------------------------------------------------
// besm_ctrl
// Sequencer: store clearing sweep, then one item at a time through setup,
// division (skipped for block reads), lookup, update and result hand-off.
// ----------------------------------------------------------------------------
module besm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  besm_pkg::status_t status,
  input  logic              out_free,
  output besm_pkg::cmd_t    cmd
);
  import besm_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_INDEX,
    S_MUL,
    S_UPDATE,
    S_FINISH,
    S_DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] div_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      div_cnt <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (status.clear_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          div_cnt <= '0;
          // A block read takes its index straight from the item.
          state   <= status.is_read ? S_INDEX : S_DIV;
        end
        S_DIV: begin
          if (div_cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_INDEX;
          end else begin
            div_cnt <= div_cnt + 1'b1;
          end
        end
        S_INDEX:  state <= S_MUL;
        S_MUL:    state <= S_UPDATE;
        S_UPDATE: state <= S_FINISH;
        S_FINISH: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.clear    = (state == S_CLEAR);
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.setup    = (state == S_SETUP);
    cmd.div_step = (state == S_DIV);
    cmd.index    = (state == S_INDEX);
    cmd.mul      = (state == S_MUL);
    cmd.update   = (state == S_UPDATE);
    cmd.finish   = (state == S_FINISH);
    cmd.push     = (state == S_DONE) && out_free;
  end

endmodule

// ===== rtl/core/besm_dp.sv =====
// ----------------------------------------------------------------------------
// besm_dp
// Datapath: configuration registers, range offset, restoring divider,
// block store, event reconstruction and query reply.
// ----------------------------------------------------------------------------
module besm_dp #(
  parameter int unsigned MAX_BLOCKS       = besm_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned MAX_BLOCK_LENGTH = besm_pkg::MAX_BLOCK_LENGTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [besm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [besm_pkg::EVENT_W-1:0]         cfg_data,
  input  besm_pkg::cmd_t                       cmd,
  input  besm_pkg::kind_t                      kind,
  input  logic [besm_pkg::EVENT_W-1:0]         event_number,
  input  logic                                 state_valid,
  input  logic                                 query_consumer,
  input  logic [besm_pkg::BLOCK_NUM_W-1:0]     block_number,
  output besm_pkg::status_t                    status,
  output besm_pkg::result_t                    result
);
  import besm_pkg::*;

  localparam int unsigned BLW_FULL = $clog2(MAX_BLOCK_LENGTH + 1);
  localparam int unsigned BLW      = (BLW_FULL < BLOCK_LEN_W) ? BLW_FULL : BLOCK_LEN_W;
  localparam int unsigned BIW      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned PW       = BIW + BLW;
  localparam int unsigned QW       = RANGE_LEN_W;
  localparam int unsigned BL_CAP_I = (MAX_BLOCK_LENGTH < (2 ** BLOCK_LEN_W))
                                     ? MAX_BLOCK_LENGTH : (2 ** BLOCK_LEN_W) - 1;
  localparam logic [BLOCK_LEN_W-1:0] BL_CAP = BLOCK_LEN_W'(BL_CAP_I);

  // Configuration registers.
  logic [EVENT_W-1:0]     range_base;
  logic [RANGE_LEN_W-1:0] range_length;
  logic [BLOCK_LEN_W-1:0] block_length;

  // Item registers.
  kind_t                  kind_r;
  logic [EVENT_W-1:0]     ev_r;
  logic                   valid_r;
  logic                   cons_r;
  logic [BLOCK_NUM_W-1:0] bnum_r;
  logic [BLW-1:0]         bl_r;

  // Working registers.
  logic                   pre_inr;
  logic                   inr;
  logic [QW-1:0]          quo;
  logic [BLW-1:0]         rem;
  logic [BIW-1:0]         blk;
  logic [PW-1:0]          prod;
  logic [BLW-1:0]         stored;
  logic [BLW-1:0]         stored_m1;
  logic [EVENT_W-1:0]     base_sum;
  logic [EVENT_W-1:0]     cur;
  logic [BIW-1:0]         clr_cnt;

  logic [BLOCK_LEN_W-1:0]     eff_bl;
  logic [EVENT_W-1:0]         offset;
  logic [BLW:0]               r_shift;
  logic [BLW:0]               r_diff;
  logic                       r_ge;
  logic [BIW+BLOCK_NUM_W-1:0] bnum_wide;
  logic                       do_update;
  logic [BLW-1:0]             new_entry;
  logic                       ram_we;
  logic [BIW-1:0]             ram_waddr;
  logic [BLW-1:0]             ram_wdata;
  logic [BLW-1:0]             ram_rdata;
  logic                       known;

  assign eff_bl    = (block_length > BL_CAP) ? BL_CAP : block_length;
  assign offset    = ev_r - range_base;
  assign r_shift   = {rem, quo[QW-1]};
  assign r_diff    = r_shift - {1'b0, bl_r};
  assign r_ge      = (r_shift >= {1'b0, bl_r});
  assign bnum_wide = (BIW + BLOCK_NUM_W)'(bnum_r);
  assign do_update = inr && ((kind_r == KIND_RECORD) ||
                             ((kind_r == KIND_IDENTIFIED) && valid_r));
  // The remainder is below the block length, so offset plus one still fits.
  assign new_entry = rem + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_base   <= '0;
      range_length <= RANGE_LEN_RST;
      block_length <= BLOCK_LEN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RANGE_BASE:   range_base   <= cfg_data;
        CFG_RANGE_LENGTH: range_length <= cfg_data[RANGE_LEN_W-1:0];
        CFG_BLOCK_LENGTH: block_length <= cfg_data[BLOCK_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      inr     <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.index) begin
        if (kind_r == KIND_READ) begin
          inr <= (bl_r != '0) && (32'(bnum_r) < MAX_BLOCKS);
        end else begin
          inr <= pre_inr && (32'(quo) < MAX_BLOCKS);
        end
      end
      if (cmd.update && (kind_r == KIND_READ)) begin
        inr <= inr && (64'(prod) < 64'(range_length));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= kind;
      ev_r    <= event_number;
      valid_r <= state_valid;
      cons_r  <= query_consumer;
      bnum_r  <= block_number;
      bl_r    <= BLW'(eff_bl);
    end
    if (cmd.setup) begin
      pre_inr <= (bl_r != '0) && (offset < 64'(range_length));
      quo     <= offset[QW-1:0];
      rem     <= '0;
    end
    if (cmd.div_step) begin
      rem <= r_ge ? r_diff[BLW-1:0] : r_shift[BLW-1:0];
      quo <= {quo[QW-2:0], r_ge};
    end
    if (cmd.index) begin
      blk <= (kind_r == KIND_READ) ? bnum_wide[BIW-1:0] : quo[BIW-1:0];
    end
    if (cmd.mul) begin
      prod <= PW'(blk) * PW'(bl_r);
    end
    if (cmd.update) begin
      stored    <= do_update ? new_entry : ram_rdata;
      stored_m1 <= (do_update ? new_entry : ram_rdata) - 1'b1;
      base_sum  <= range_base + 64'(prod);
    end
    if (cmd.finish) begin
      cur <= base_sum + 64'(stored_m1);
    end
  end

  assign ram_we    = cmd.clear || (cmd.update && do_update);
  assign ram_waddr = cmd.clear ? clr_cnt : blk;
  assign ram_wdata = cmd.clear ? '0 : new_entry;

  besm_ram #(
    .WIDTH (BLW),
    .DEPTH (MAX_BLOCKS),
    .ADDR_W(BIW)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (cmd.mul),
    .rd_addr(blk),
    .rd_data(ram_rdata)
  );

  assign status.clear_last = (clr_cnt == BIW'(MAX_BLOCKS - 1));
  assign status.is_read    = (kind_r == KIND_READ);

  assign known = inr && (stored != '0);

  always_comb begin
    result               = '0;
    result.in_range      = inr;
    result.block_known   = known;
    result.current_event = known ? cur : '0;
    if (inr && (kind_r == KIND_QUERY)) begin
      result.reply_code = {cons_r, !(known && (cur == ev_r))};
    end
  end

endmodule

// ===== rtl/core/block_event_state_memory.sv =====
// Block event state memory: remembers the last valid event of each block.
// Items are taken one at a time: a new item is accepted only after the result of the last
// one has entered the result register. Block reads skip the restoring divider, which
// takes one bit of the 19-bit range offset a cycle.
// Reset: the configuration registers return to their defaults and the store is swept to
// zero, one entry a cycle over all MAX_BLOCKS entries, while s_axis_tready stays low.
// ----------------------------------------------------------------------------
// block_event_state_memory
// Top level: stream ports, configuration port, result register.
// ----------------------------------------------------------------------------
module block_event_state_memory #(
  parameter int unsigned MAX_BLOCKS       = besm_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned MAX_BLOCK_LENGTH = besm_pkg::MAX_BLOCK_LENGTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // event_number[63:0], state_valid[64], query_consumer[65], block_number[73:66]
  input  logic [besm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // kind[1:0]
  input  logic [besm_pkg::KIND_W-1:0]      s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // in_range[0], block_known[1], current_event[65:2], reply_code[67:66]
  output logic [besm_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [besm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [besm_pkg::EVENT_W-1:0]     cfg_data
);
  import besm_pkg::*;

  cmd_t    cmd;
  status_t status;
  result_t result;
  result_t out_res;
  logic    out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  besm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .status  (status),
    .out_free(out_free),
    .cmd     (cmd)
  );

  besm_dp #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .MAX_BLOCK_LENGTH(MAX_BLOCK_LENGTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .kind          (kind_t'(s_axis_tuser)),
    .event_number  (s_axis_tdata[63:0]),
    .state_valid   (s_axis_tdata[64]),
    .query_consumer(s_axis_tdata[65]),
    .block_number  (s_axis_tdata[73:66]),
    .status        (status),
    .result        (result)
  );

  // The result register frees the sequencer while a result waits downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_res <= result;
    end
  end

  assign m_axis_tdata = {(M_TDATA_W - $bits(result_t))'(0), out_res};

  // An item holds the block until its result is handed off.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in progress");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[67:1] == '0))
    else $error("out of range result carries nonzero fields");

  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[65:2] == '0))
    else $error("unknown block reports a nonzero event");

  // The clearing sweep follows every reset with no item taken and no result shown.
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> (!s_axis_tready && !m_axis_tvalid))
    else $error("block active right after reset");

endmodule

// ===== verif/tb_block_event_state_memory.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_event_state_memory
// Self-checking bench for the block event state memory. A shadow copy of the
// per-block store and of the range registers predicts every result. Random
// event traffic runs over several range settings with back-pressure on both
// streams.
// ----------------------------------------------------------------------------
module tb_block_event_state_memory;
  import besm_pkg::*;

  localparam int unsigned NUM_BLOCKS = MAX_BLOCKS_DEF;
  localparam int unsigned BLEN_CAP   = MAX_BLOCK_LENGTH_DEF;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned RUN_LIMIT_NS = 6_000_000;
  localparam int unsigned NUM_PHASES = 9;

  typedef struct {
    kind_t            kind;
    logic [63:0]      event_number;
    logic             state_valid;
    logic             query_consumer;
    logic [7:0]       block_number;
  } stim_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [KIND_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [EVENT_W-1:0] cfg_data = '0;

  // Shadow registers and store.
  logic [63:0] range_base_q = '0;
  logic [RANGE_LEN_W-1:0] range_len_q = RANGE_LEN_RST;
  logic [BLOCK_LEN_W-1:0] block_len_q = BLOCK_LEN_RST;
  logic [10:0] block_memory [NUM_BLOCKS];

  stim_item_t pending_items[$];
  stim_item_t driven_item;
  result_t expected_results[$];
  logic [63:0] recent_events[$];
  logic item_taken = 1'b0;

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int issued_count = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int in_range_count = 0;
  int known_count = 0;
  int mismatches = 0;
  int reg_writes = 0;
  int kind_count[4] = '{0, 0, 0, 0};

  always #6 clk = ~clk;

  block_event_state_memory dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Works out the result of one item and applies its update to the shadow store.
  function automatic result_t predict_memory_result(input stim_item_t it);
    logic [63:0] blen, offset, blk, inner_off;
    logic [10:0] stored;
    logic hit;
    result_t r;
    r = '0;
    hit = 1'b0;
    blk = '0;
    blen = (block_len_q > BLEN_CAP) ? 64'(BLEN_CAP) : 64'(block_len_q);
    if (it.kind == KIND_READ) begin
      if (blen != 0 && 64'(it.block_number) * blen < 64'(range_len_q)) begin
        hit = 1'b1;
        blk = 64'(it.block_number);
      end
    end else begin
      offset = it.event_number - range_base_q;
      if (blen != 0 && offset < 64'(range_len_q)) begin
        blk = offset / blen;
        if (blk < NUM_BLOCKS) begin
          hit = 1'b1;
          if (it.kind == KIND_RECORD || (it.kind == KIND_IDENTIFIED && it.state_valid)) begin
            inner_off = offset - blk * blen;
            block_memory[blk] = inner_off[10:0] + 11'd1;
          end
        end
      end
    end
    if (hit) begin
      r.in_range = 1'b1;
      stored = block_memory[blk];
      if (stored != 0) begin
        r.block_known = 1'b1;
        r.current_event = range_base_q + blk * blen + 64'(stored) - 64'd1;
      end
      if (it.kind == KIND_QUERY) begin
        r.reply_code = {it.query_consumer,
                        !(r.block_known && r.current_event == it.event_number)};
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want_v, got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
    end
  endtask

  always @(negedge clk) begin : item_driver
    stim_item_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || item_taken) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        nxt = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, nxt.block_number, nxt.query_consumer, nxt.state_valid,
                          nxt.event_number};
        s_axis_tuser  <= nxt.kind;
        driven_item   <= nxt;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin : result_monitor
    result_t got, want;
    item_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_memory_result(driven_item));
        accepted_count++;
        kind_count[driven_item.kind]++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[67:0]);
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with nothing pending, expected none, got %h",
                   $time, got);
        end else begin
          want = expected_results.pop_front();
          check_field("in_range", 64'(want.in_range), 64'(got.in_range));
          check_field("block_known", 64'(want.block_known), 64'(got.block_known));
          check_field("current_event", want.current_event, got.current_event);
          check_field("reply_code", 64'(want.reply_code), 64'(got.reply_code));
          checked_count++;
          in_range_count += int'(want.in_range);
          known_count += int'(want.block_known);
        end
      end
    end
  end

  function automatic stim_item_t make_item(input kind_t kind, input logic [63:0] ev,
                                           input logic valid, input logic consumer,
                                           input logic [7:0] bnum);
    stim_item_t it;
    it.kind = kind;
    it.event_number = ev;
    it.state_valid = valid;
    it.query_consumer = consumer;
    it.block_number = bnum;
    return it;
  endfunction

  // Most events land in or just past the range; some reuse recorded events so
  // that queries also see the valid reply.
  function automatic stim_item_t make_random_item();
    stim_item_t it;
    int sel;
    int span;
    int nblocks;
    int blen;
    it.kind = kind_t'($urandom_range(0, 3));
    it.state_valid = 1'($urandom_range(0, 1));
    it.query_consumer = 1'($urandom_range(0, 1));
    span = int'(range_len_q) + int'(range_len_q) / 8 + 2;
    sel = $urandom_range(0, 99);
    if (sel < 70 || (sel < 80 && recent_events.size() == 0))
      it.event_number = range_base_q + 64'($urandom_range(0, span));
    else if (sel < 80)
      it.event_number = recent_events[$urandom_range(0, recent_events.size() - 1)];
    else if (sel < 90)
      it.event_number = {$urandom, $urandom};
    else
      it.event_number = range_base_q - 64'($urandom_range(1, 16));
    blen = (block_len_q > BLEN_CAP) ? BLEN_CAP : int'(block_len_q);
    if (blen != 0 && $urandom_range(0, 3) != 0) begin
      nblocks = int'(range_len_q) / blen + 1;
      it.block_number = 8'($urandom_range(0, (nblocks > 255) ? 255 : nblocks));
    end else begin
      it.block_number = 8'($urandom_range(0, 255));
    end
    if (it.kind == KIND_RECORD || (it.kind == KIND_IDENTIFIED && it.state_valid)) begin
      recent_events.push_back(it.event_number);
      if (recent_events.size() > 16) void'(recent_events.pop_front());
    end
    return it;
  endfunction

  task automatic push_item(input stim_item_t it);
    pending_items.push_back(it);
    issued_count++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_count != issued_count || expected_results.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      CFG_RANGE_BASE:   range_base_q = value;
      CFG_RANGE_LENGTH: range_len_q = value[RANGE_LEN_W-1:0];
      CFG_BLOCK_LENGTH: block_len_q = value[BLOCK_LEN_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input int count, input bit pause_midway);
    for (int i = 0; i < count; i++) begin
      // Hold the sender back until every outstanding result is in.
      if (pause_midway && i == count / 2) wait_drained();
      push_item(make_random_item());
    end
    wait_drained();
  endtask

  initial begin : stimulus
    static int phase_items[NUM_PHASES] = '{70, 65, 65, 65, 55, 65, 30, 65, 70};
    for (int b = 0; b < NUM_BLOCKS; b++) block_memory[b] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings: base 0, 1024 events, blocks of 4.
    sender_idle_pct = 32;
    receiver_idle_pct = 45;
    push_item(make_item(KIND_READ, 64'd0, 1'b0, 1'b0, 8'd0));
    push_item(make_item(KIND_QUERY, 64'd5, 1'b0, 1'b0, 8'd0));
    push_item(make_item(KIND_RECORD, 64'd5, 1'b0, 1'b0, 8'd0));
    push_item(make_item(KIND_QUERY, 64'd5, 1'b0, 1'b0, 8'd0));
    push_item(make_item(KIND_QUERY, 64'd5, 1'b0, 1'b1, 8'd0));
    push_item(make_item(KIND_QUERY, 64'd6, 1'b0, 1'b1, 8'd0));
    push_item(make_item(KIND_IDENTIFIED, 64'd6, 1'b0, 1'b0, 8'd0));
    push_item(make_item(KIND_IDENTIFIED, 64'd7, 1'b1, 1'b0, 8'd0));
    push_item(make_item(KIND_READ, 64'd0, 1'b0, 1'b0, 8'd1));
    push_item(make_item(KIND_RECORD, 64'd1023, 1'b1, 1'b1, 8'd255));
    push_item(make_item(KIND_RECORD, 64'd1024, 1'b0, 1'b0, 8'd0));
    push_item(make_item(KIND_IDENTIFIED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 8'd255));
    push_item(make_item(KIND_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 8'd255));
    push_item(make_item(KIND_READ, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 8'd255));
    push_item(make_item(KIND_QUERY, 64'd0, 1'b0, 1'b1, 8'd0));
    push_item(make_item(KIND_RECORD, 64'd0, 1'b0, 1'b0, 8'd0));
    push_item(make_item(KIND_READ, 64'd0, 1'b0, 1'b0, 8'd0));
    push_item(make_item(KIND_QUERY, 64'd1023, 1'b0, 1'b0, 8'd0));
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 3) begin
        sender_idle_pct = 32;
        receiver_idle_pct = 45;
      end else if (p < 6) begin
        sender_idle_pct = 45;
        receiver_idle_pct = 32;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      case (p)
        1: begin
          // Range wraps through zero.
          write_register(CFG_RANGE_BASE, 64'hFFFF_FFFF_FFFF_FF00);
          write_register(CFG_RANGE_LENGTH, 64'd1000);
        end
        2: begin
          write_register(CFG_RANGE_BASE, {$urandom, $urandom});
          write_register(CFG_RANGE_LENGTH, 64'd262144);
          write_register(CFG_BLOCK_LENGTH, 64'd1024);
        end
        3: begin
          // All-ones writes: length masks to 19 bits and the block length is
          // clamped, so blocks past the store are out of range.
          write_register(CFG_RANGE_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
          write_register(CFG_BLOCK_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
        end
        4: begin
          write_register(CFG_RANGE_BASE, 64'd0);
          write_register(CFG_RANGE_LENGTH, 64'd1);
          write_register(CFG_BLOCK_LENGTH, 64'd1);
          write_register(CFG_SPARE, {$urandom, $urandom});
        end
        5: begin
          // 100 events in blocks of 3 leaves a partial last block.
          write_register(CFG_RANGE_BASE, 64'h0123_4567_89AB_CDEF);
          write_register(CFG_RANGE_LENGTH, 64'd100);
          write_register(CFG_BLOCK_LENGTH, 64'd3);
        end
        6: begin
          write_register(CFG_BLOCK_LENGTH, 64'd0);
          write_register(CFG_RANGE_LENGTH, 64'h8_0000);
        end
        7: begin
          write_register(CFG_RANGE_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
          write_register(CFG_RANGE_LENGTH, 64'd256);
          write_register(CFG_BLOCK_LENGTH, 64'd1);
        end
        8: begin
          write_register(CFG_RANGE_BASE, 64'd1000);
          write_register(CFG_RANGE_LENGTH, 64'd1792);
          write_register(CFG_BLOCK_LENGTH, 64'd7);
        end
        default: ;
      endcase
      run_random_phase(phase_items[p], p == 1);
    end

    repeat (30) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatches++;
      $display("%0t ns: %0d results never arrived, expected 0 pending, got %0d",
               $time, expected_results.size(), expected_results.size());
    end
    $display("Sent %0d items (record %0d, identified %0d, query %0d, read %0d)",
             accepted_count, kind_count[KIND_RECORD], kind_count[KIND_IDENTIFIED],
             kind_count[KIND_QUERY], kind_count[KIND_READ]);
    $display("over %0d register writes; checked %0d results, %0d in range and %0d known.",
             reg_writes, checked_count, in_range_count, known_count);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
